### hw/rtl/wbxc_pkg.sv
// Package for the wide-block xorshift cipher: block geometry, payload structs,
// register indexes, sequencer states and the word spreading function.
// No dependencies; used by wbxc_permuter and wide_block_xorshift_cipher.
package wbxc_pkg;

  localparam int WORDS     = 4;
  localparam int KEY_WORDS = 4;
  localparam int IDX_W     = (WORDS > 2) ? $clog2(WORDS) : 1;
  localparam int STEPS     = 2 * (WORDS - 1);
  localparam int STEP_W    = (STEPS > 2) ? $clog2(STEPS) : 1;

  localparam logic [63:0] MIX_CONST = 64'h0123456789ABCDEF;

  typedef logic [63:0] word_t;
  typedef word_t [WORDS-1:0] block_t;
  typedef word_t [KEY_WORDS-1:0] key_t;

  localparam logic REQ_DATA  = 1'b0;
  localparam logic REQ_NONCE = 1'b1;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_ROUND_COUNT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECRYPT_MODE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_0   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_1   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_2   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_3   = 3'd5;

  typedef struct packed {
    logic  req_type;
    word_t data_word;
  } req_beat_t;

  typedef struct packed {
    word_t result_word;
    logic  last_word;
  } rsp_beat_t;

  // Control from the sequencer to the shared permutation unit.
  typedef struct packed {
    logic       start;
    logic       inverse;
    logic [7:0] rounds;
  } perm_ctrl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_START1,
    S_RUN1,
    S_RUN2
  } state_t;

  function automatic word_t spread(input word_t v);
    spread = (v << 1) ^ v ^ (v >> 1) ^ MIX_CONST;
  endfunction

endpackage

### hw/rtl/wbxc_permuter.sv
// Iterative permutation unit: one neighbour word update per clock cycle.
// Runs the forward mix or its inverse over a block for a given round count.
// Depends on wbxc_pkg.
module wbxc_permuter (
  input  logic               clk,
  input  logic               rst,
  input  wbxc_pkg::perm_ctrl_t ctrl,
  input  wbxc_pkg::block_t   load,
  output logic               busy,
  output wbxc_pkg::block_t   words
);

  localparam logic [wbxc_pkg::STEP_W-1:0] LAST_STEP = wbxc_pkg::STEP_W'(wbxc_pkg::STEPS - 1);
  localparam logic [wbxc_pkg::STEP_W-1:0] HALF      = wbxc_pkg::STEP_W'(wbxc_pkg::WORDS - 1);
  localparam logic [wbxc_pkg::STEP_W-1:0] TURN      = wbxc_pkg::STEP_W'(wbxc_pkg::STEPS);

  wbxc_pkg::block_t            w;
  wbxc_pkg::word_t             carry;
  logic [wbxc_pkg::STEP_W-1:0] step;
  logic [7:0]                  round;
  logic [7:0]                  rounds;
  logic                        inv;

  logic [wbxc_pkg::STEP_W-1:0] fidx;
  logic [wbxc_pkg::STEP_W-1:0] j;
  logic [wbxc_pkg::IDX_W-1:0]  src;
  logic [wbxc_pkg::IDX_W-1:0]  dst;
  wbxc_pkg::word_t             rd;
  wbxc_pkg::word_t             nw;
  wbxc_pkg::word_t             carry_next;

  // The inverse runs the forward update list backwards. In forward order the
  // source of each update is the word just written; in inverse order the
  // destination is the source read one step before. Either way one word is
  // carried and only one word is read from the array each cycle.
  always_comb begin
    fidx = inv ? (LAST_STEP - step) : step;
    j    = TURN - fidx;
    if (fidx < HALF) begin
      src = fidx[wbxc_pkg::IDX_W-1:0];
      dst = src + wbxc_pkg::IDX_W'(1);
    end else begin
      src = j[wbxc_pkg::IDX_W-1:0];
      dst = src - wbxc_pkg::IDX_W'(1);
    end
    rd = inv ? w[src] : w[dst];
    if (inv) begin
      nw         = carry ^ wbxc_pkg::spread(rd);
      carry_next = rd;
    end else begin
      nw         = rd ^ wbxc_pkg::spread(carry);
      carry_next = nw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      step  <= '0;
      round <= '0;
    end else if (ctrl.start) begin
      busy  <= (ctrl.rounds != 8'd0);
      step  <= '0;
      round <= '0;
    end else if (busy) begin
      if (step == LAST_STEP) begin
        step  <= '0;
        round <= round + 8'd1;
        if (round == rounds - 8'd1) begin
          busy <= 1'b0;
        end
      end else begin
        step <= step + wbxc_pkg::STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      w      <= load;
      carry  <= load[0];
      inv    <= ctrl.inverse;
      rounds <= ctrl.rounds;
    end else if (busy) begin
      w[dst] <= nw;
      carry  <= carry_next;
    end
  end

  assign words = w;

endmodule

### hw/rtl/wide_block_xorshift_cipher.sv
// Top level of the wide-block xorshift cipher: beat gathering, nonce counter,
// sequencer around the shared permutation unit and the result buffer.
// Depends on wbxc_pkg and wbxc_permuter.
//
// Usage. Request beats arrive on req_valid/req_stall with req_beat. A beat
// with req_type set loads one nonce word, most significant word first; a
// beat with req_type clear is one data word of a block, in block order.
// Registers are written on cfg_valid/cfg_ready (ready is always high) with
// cfg_index and cfg_data; the user must write them only while the block is
// idle, which the block itself does not enforce. When the last data word of
// a block is taken, req_stall rises and the block runs two permutations,
// each of round_count rounds, on one shared unit that updates one word per
// cycle; req_stall stays high until the result block is in the output buffer.
// The result block is copied into an output buffer and sent as WORDS response
// beats on rsp_valid/rsp_stall, the final one with last_word set. Gathering
// of the next block goes on while the buffer drains; a finished block waits
// in the permutation unit for as long as the receiver stalls the previous one.
// Reset clears the nonce, the gathering positions and the registers to their
// defaults (12 rounds, encrypt, zero key); no beat is pending after reset.
module wide_block_xorshift_cipher (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_stall,
  input  wbxc_pkg::req_beat_t               req_beat,
  output logic                              rsp_valid,
  input  logic                              rsp_stall,
  output wbxc_pkg::rsp_beat_t               rsp_beat,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [wbxc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [63:0]                       cfg_data
);

  localparam logic [wbxc_pkg::IDX_W-1:0] LAST_IDX = wbxc_pkg::IDX_W'(wbxc_pkg::WORDS - 1);

  // Configuration registers.
  logic [7:0]          round_count;
  logic                decrypt_mode;
  wbxc_pkg::key_t      key_word;

  // Sequencer and gathering state.
  wbxc_pkg::state_t    state;
  wbxc_pkg::state_t    state_next;
  logic [wbxc_pkg::IDX_W-1:0] word_pos;
  logic [wbxc_pkg::IDX_W-1:0] nonce_pos;
  wbxc_pkg::block_t    nonce;
  wbxc_pkg::block_t    nonce_inc;
  wbxc_pkg::block_t    blk;

  // Output buffer.
  wbxc_pkg::block_t    obuf;
  logic [wbxc_pkg::IDX_W-1:0] rsp_idx;

  // Permutation unit interface.
  wbxc_pkg::perm_ctrl_t pctrl;
  wbxc_pkg::block_t    pload;
  wbxc_pkg::block_t    perm_words;
  logic                perm_busy;

  wbxc_pkg::block_t    keyv;
  wbxc_pkg::block_t    key_nonce;
  logic                req_acc;
  logic                rsp_acc;
  logic                run1_done;
  logic                finish;
  logic                inc_carry;

  assign cfg_ready = 1'b1;
  assign req_stall = (state != wbxc_pkg::S_IDLE);
  assign req_acc   = req_valid && !req_stall;
  assign rsp_acc   = rsp_valid && !rsp_stall;

  // Key words beyond the block width are unused. The nonce increments as one
  // big-endian counter: a word steps when every less significant word wraps.
  always_comb begin
    inc_carry = 1'b1;
    for (int i = wbxc_pkg::WORDS - 1; i >= 0; i--) begin
      keyv[i]      = key_word[i];
      key_nonce[i] = key_word[i] ^ nonce[i];
      nonce_inc[i] = nonce[i] + {63'd0, inc_carry};
      inc_carry    = inc_carry && (nonce[i] == '1);
    end
  end

  // Encryption: keystream first (forward), then the whitened block (forward),
  // then the key. Decryption: the keyed block through the inverse first, then
  // the keystream, which is folded in at the end.
  always_comb begin
    state_next   = state;
    pctrl.start  = 1'b0;
    pctrl.inverse = 1'b0;
    pctrl.rounds = round_count;
    pload        = key_nonce;
    run1_done    = 1'b0;
    finish       = 1'b0;
    case (state)
      wbxc_pkg::S_IDLE: begin
        if (req_acc && (req_beat.req_type == wbxc_pkg::REQ_DATA) && (word_pos == LAST_IDX)) begin
          state_next = wbxc_pkg::S_START1;
        end
      end
      wbxc_pkg::S_START1: begin
        pctrl.start   = 1'b1;
        pctrl.inverse = decrypt_mode;
        pload         = decrypt_mode ? (blk ^ keyv) : key_nonce;
        state_next    = wbxc_pkg::S_RUN1;
      end
      wbxc_pkg::S_RUN1: begin
        if (!perm_busy) begin
          run1_done   = 1'b1;
          pctrl.start = 1'b1;
          pload       = decrypt_mode ? key_nonce : (blk ^ perm_words);
          state_next  = wbxc_pkg::S_RUN2;
        end
      end
      wbxc_pkg::S_RUN2: begin
        if (!perm_busy && !rsp_valid) begin
          finish     = 1'b1;
          state_next = wbxc_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = wbxc_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wbxc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration, nonce and positions.
  always_ff @(posedge clk) begin
    if (rst) begin
      round_count  <= 8'd12;
      decrypt_mode <= 1'b0;
      key_word     <= '0;
      nonce        <= '0;
      word_pos     <= '0;
      nonce_pos    <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          wbxc_pkg::CFG_ROUND_COUNT:  round_count  <= cfg_data[7:0];
          wbxc_pkg::CFG_DECRYPT_MODE: decrypt_mode <= cfg_data[0];
          wbxc_pkg::CFG_KEY_WORD_0:   key_word[0]  <= cfg_data;
          wbxc_pkg::CFG_KEY_WORD_1:   key_word[1]  <= cfg_data;
          wbxc_pkg::CFG_KEY_WORD_2:   key_word[2]  <= cfg_data;
          wbxc_pkg::CFG_KEY_WORD_3:   key_word[3]  <= cfg_data;
          default: ;
        endcase
      end
      if (req_acc) begin
        if (req_beat.req_type == wbxc_pkg::REQ_NONCE) begin
          nonce[nonce_pos] <= req_beat.data_word;
          nonce_pos <= (nonce_pos == LAST_IDX) ? '0 : nonce_pos + wbxc_pkg::IDX_W'(1);
        end else begin
          word_pos <= (word_pos == LAST_IDX) ? '0 : word_pos + wbxc_pkg::IDX_W'(1);
        end
      end
      // The run that loads the nonce has taken it by the time run one is done.
      if (run1_done) begin
        nonce <= nonce_inc;
      end
    end
  end

  // Block data; no reset needed.
  always_ff @(posedge clk) begin
    if (req_acc && (req_beat.req_type == wbxc_pkg::REQ_DATA)) begin
      blk[word_pos] <= req_beat.data_word;
    end
    if (run1_done && decrypt_mode) begin
      blk <= perm_words;
    end
    if (finish) begin
      obuf <= decrypt_mode ? (blk ^ perm_words) : (perm_words ^ keyv);
    end
  end

  // Response beats from the output buffer.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
      rsp_idx   <= '0;
    end else if (finish) begin
      rsp_valid <= 1'b1;
      rsp_idx   <= '0;
    end else if (rsp_acc) begin
      if (rsp_idx == LAST_IDX) begin
        rsp_valid <= 1'b0;
        rsp_idx   <= '0;
      end else begin
        rsp_idx <= rsp_idx + wbxc_pkg::IDX_W'(1);
      end
    end
  end

  assign rsp_beat.result_word = obuf[rsp_idx];
  assign rsp_beat.last_word   = (rsp_idx == LAST_IDX);

  wbxc_permuter u_permuter (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (pctrl),
    .load  (pload),
    .busy  (perm_busy),
    .words (perm_words)
  );

  // The permutation unit only runs while the sequencer waits on it.
  a_busy_in_run: assert property (@(posedge clk) disable iff (rst)
    perm_busy |-> (state == wbxc_pkg::S_RUN1 || state == wbxc_pkg::S_RUN2))
    else $error("permutation unit busy outside a run state");

  // A new result block only appears when the second run finishes.
  a_rsp_from_run2: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> ($past(state) == wbxc_pkg::S_RUN2))
    else $error("result block started outside the second run");

  // After the final beat of a block goes out, the buffer is empty.
  a_last_drains: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_stall && rsp_beat.last_word) |=> !rsp_valid)
    else $error("result buffer still valid after its final beat");

  // A block is only processed once it has been gathered completely.
  a_gather_reset: assert property (@(posedge clk) disable iff (rst)
    (state != wbxc_pkg::S_IDLE) |-> (word_pos == '0))
    else $error("gathering position not cleared during processing");

endmodule

### tb/sv/wbxc_result_check.sv
// Result checker for the wide-block xorshift cipher testbench: follows the
// request, response and register channels, predicts every response beat and compares.
// Depends on wbxc_pkg for the payload structs, register indexes and block geometry.
module wbxc_result_check (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  input  logic                           req_stall,
  input  wbxc_pkg::req_beat_t            req_beat,
  input  logic                           rsp_valid,
  input  logic                           rsp_stall,
  input  wbxc_pkg::rsp_beat_t            rsp_beat,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [wbxc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                    cfg_data,
  output int                             mismatches,
  output int                             waiting_beats
);
  timeunit 1ns;
  timeprecision 1ps;

  import wbxc_pkg::*;

  // Mirror of the block's registers and cipher state.
  logic [7:0] round_count_q;
  logic       decrypt_q;
  key_t       key_q;
  block_t     nonce_q;
  block_t     gathered_q;
  int         gather_pos;
  int         nonce_pos;

  // Response beats still owed by the block, oldest first.
  rsp_beat_t  cipher_out_q[$];

  function automatic word_t diffuse(input word_t v);
    return (v << 1) ^ v ^ (v >> 1) ^ MIX_CONST;
  endfunction

  function automatic block_t scramble(input block_t w, input logic [7:0] rounds);
    for (int r = 0; r < rounds; r++) begin
      for (int j = 0; j < WORDS - 1; j++) w[j + 1] ^= diffuse(w[j]);
      for (int j = WORDS - 1; j > 0; j--) w[j - 1] ^= diffuse(w[j]);
    end
    return w;
  endfunction

  // Same word updates as scramble, applied in the opposite order.
  function automatic block_t unscramble(input block_t w, input logic [7:0] rounds);
    for (int r = 0; r < rounds; r++) begin
      for (int j = 1; j < WORDS; j++) w[j - 1] ^= diffuse(w[j]);
      for (int j = WORDS - 2; j >= 0; j--) w[j + 1] ^= diffuse(w[j]);
    end
    return w;
  endfunction

  function automatic block_t cipher_block(input block_t text);
    block_t stream;
    block_t key_blk;
    for (int i = 0; i < WORDS; i++) begin
      key_blk[i] = key_q[i];
      stream[i]  = key_q[i] ^ nonce_q[i];
    end
    stream = scramble(stream, round_count_q);
    if (decrypt_q) begin
      return unscramble(text ^ key_blk, round_count_q) ^ stream;
    end
    return scramble(text ^ stream, round_count_q) ^ key_blk;
  endfunction

  always @(posedge clk) begin : track
    rsp_beat_t want;
    block_t    out_blk;
    logic      carry;
    if (rst) begin
      round_count_q = 8'd12;
      decrypt_q     = 1'b0;
      key_q         = '0;
      nonce_q       = '0;
      gathered_q    = '0;
      gather_pos    = 0;
      nonce_pos     = 0;
      cipher_out_q.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (cipher_out_q.size() == 0) begin
          $error("result beat with nothing expected: result_word %h last_word %b",
                 rsp_beat.result_word, rsp_beat.last_word);
          mismatches++;
        end else begin
          want = cipher_out_q.pop_front();
          if (rsp_beat.result_word !== want.result_word) begin
            $error("result_word: expected %h, got %h", want.result_word, rsp_beat.result_word);
            mismatches++;
          end
          if (rsp_beat.last_word !== want.last_word) begin
            $error("last_word: expected %b, got %b", want.last_word, rsp_beat.last_word);
            mismatches++;
          end
        end
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ROUND_COUNT:  round_count_q = cfg_data[7:0];
          CFG_DECRYPT_MODE: decrypt_q = cfg_data[0];
          CFG_KEY_WORD_0:   key_q[0] = cfg_data;
          CFG_KEY_WORD_1:   key_q[1] = cfg_data;
          CFG_KEY_WORD_2:   key_q[2] = cfg_data;
          CFG_KEY_WORD_3:   key_q[3] = cfg_data;
          default: ;
        endcase
      end

      if (req_valid && !req_stall) begin
        if (req_beat.req_type == REQ_NONCE) begin
          nonce_q[nonce_pos] = req_beat.data_word;
          nonce_pos = (nonce_pos + 1) % WORDS;
        end else begin
          gathered_q[gather_pos] = req_beat.data_word;
          if (gather_pos < WORDS - 1) begin
            gather_pos++;
          end else begin
            gather_pos = 0;
            out_blk = cipher_block(gathered_q);
            for (int i = 0; i < WORDS; i++) begin
              want.result_word = out_blk[i];
              want.last_word   = (i == WORDS - 1);
              cipher_out_q.push_back(want);
            end
            // Big-endian counter: the carry runs from the last word upward.
            carry = 1'b1;
            for (int i = WORDS - 1; i >= 0; i--) begin
              if (carry) begin
                nonce_q[i] = nonce_q[i] + 64'd1;
                carry = (nonce_q[i] == '0);
              end
            end
          end
        end
      end
    end
    waiting_beats = cipher_out_q.size();
  end

endmodule

### tb/sv/wide_block_xorshift_cipher_test.sv
// Top of the wide-block xorshift cipher testbench: clock, reset, stimulus,
// register writes, receiver stalls, watchdog and the final verdict.
// Depends on wbxc_pkg, the cipher RTL and wbxc_result_check.
module wide_block_xorshift_cipher_test;
  timeunit 1ns;
  timeprecision 1ps;

  import wbxc_pkg::*;

  // Quiet cycles tolerated before the run is declared hung. The slowest
  // legal quiet stretch is one 255-round block or the long receiver hold
  // below, so this leaves a wide margin.
  localparam int QUIET_LIMIT   = 20000;
  // Cycles allowed after the last expected beat before registers change.
  localparam int DRAIN_CYCLES  = 160;
  // Length of the receiver hold that backs the block up to its input.
  localparam int HOLD_CYCLES   = 600;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 64;
  localparam int SLOW_ITEMS    = 16;
  // First register index past the key words; writes there must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = CFG_KEY_WORD_3 + 3'd1;

  logic                 clk;
  logic                 rst       = 1'b1;
  logic                 req_valid = 1'b0;
  logic                 req_stall;
  req_beat_t            req_beat  = '0;
  logic                 rsp_valid;
  logic                 rsp_stall = 1'b0;
  rsp_beat_t            rsp_beat;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [63:0]          cfg_data  = '0;

  // Percentages of cycles in which the sender idles and the receiver stalls.
  int idle_pct   = 0;
  int stall_pct  = 0;
  // Bumped by the stimulus to ask the receiver for one long hold.
  int hold_asked = 0;

  int mismatches;
  int waiting_beats;

  wide_block_xorshift_cipher dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_beat  (req_beat),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_beat  (rsp_beat),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  wbxc_result_check result_check (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .req_beat      (req_beat),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .rsp_beat      (rsp_beat),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .waiting_beats (waiting_beats)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver. Each cycle it stalls with the phase's probability, except
  // during a requested hold, which it counts down here on its own.
  initial begin : receiver
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_asked) begin
        hold_seen = hold_asked;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Watchdog. Any accepted beat on any channel restarts the count. The
  // signals are read at the edge, before the edge's updates land.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("wide_block_xorshift_cipher_test failed");
    $finish;
  end

  function automatic word_t rand_word();
    return {$urandom, $urandom};
  endfunction

  // Data words lean toward the extremes now and then.
  function automatic word_t pick_word();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return word_t'(1) << $urandom_range(63);
      default: return rand_word();
    endcase
  endfunction

  // Offers one request beat and returns at the edge that accepts it, with
  // valid still high. A gap, if any, is taken before the beat is offered,
  // so valid is never lowered and raised within the same time step. The
  // stall is looked at on the falling edge, where it has settled.
  task automatic offer(input logic kind, input word_t w);
    if ($urandom_range(99) < idle_pct) begin
      req_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    req_valid <= 1'b1;
    req_beat  <= {kind, w};
    do @(negedge clk); while (req_stall);
    @(posedge clk);
  endtask

  // One register write beat; valid is left high for a following write.
  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input word_t val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
  endtask

  // Waits until every predicted beat has come out, then lets a block that
  // may still be busy with a nonce load or a partial block settle. The
  // first edge makes sure the checker has seen the last accepted beat.
  task automatic settle();
    @(posedge clk);
    wait (waiting_beats == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Rewrites every register while the block is idle. Unused data bits carry
  // noise, and a write to an index past the key words comes last, so that
  // a block which wrongly took it would be caught on the next block.
  task automatic set_cipher(input logic [7:0] rounds, input logic dec, input key_t key);
    word_t noise;
    settle();
    noise = rand_word();
    put_reg(CFG_ROUND_COUNT, {noise[63:8], rounds});
    noise = rand_word();
    put_reg(CFG_DECRYPT_MODE, {noise[63:1], dec});
    for (int k = 0; k < KEY_WORDS; k++) begin
      put_reg(CFG_KEY_WORD_0 + 3'(k), key[k]);
    end
    put_reg(CFG_UNUSED_LO + 3'($urandom_range(1)), rand_word());
    cfg_valid <= 1'b0;
  endtask

  // One well-formed block of data beats. Now and then a run of nonce loads
  // is slipped in somewhere, often a full nonce, sometimes a broken one
  // that leaves the load position part way, sometimes one that wraps it.
  task automatic send_group(inout int count);
    int    split;
    int    loads;
    logic  all_ones;
    split = -1;
    loads = 0;
    if ($urandom_range(99) < 20) begin
      split = $urandom_range(WORDS);
      loads = ($urandom_range(1) == 0) ? WORDS : $urandom_range(1, WORDS + 1);
    end
    // An all-ones nonce makes the next increment carry through every word.
    all_ones = ($urandom_range(2) == 0);
    for (int i = 0; i <= WORDS; i++) begin
      if (i == split) begin
        for (int n = 0; n < loads; n++) begin
          offer(REQ_NONCE, all_ones ? '1 : pick_word());
          count++;
        end
      end
      if (i < WORDS) begin
        offer(REQ_DATA, pick_word());
        count++;
      end
    end
  endtask

  initial begin : stimulus
    int         count;
    int         quota;
    logic [7:0] rounds;
    logic       dec;
    key_t       key;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. The first two blocks run on the reset settings:
    // twelve rounds, encryption, zero key and a nonce counting up from zero.
    for (int i = 0; i < WORDS; i++) offer(REQ_DATA, '0);
    for (int i = 0; i < WORDS; i++) offer(REQ_DATA, '1);
    req_valid <= 1'b0;

    // Zero rounds: only the key and keystream whitening remain.
    for (int k = 0; k < KEY_WORDS; k++) key[k] = rand_word();
    set_cipher(8'd0, 1'b0, key);
    offer(REQ_DATA, 64'h8000_0000_0000_0000);
    offer(REQ_DATA, 64'h0000_0000_0000_0001);
    offer(REQ_DATA, '1);
    offer(REQ_DATA, '0);

    // A full nonce load in the middle of a block must leave the gathered
    // half alone. The all-ones nonce then wraps to zero after the block.
    offer(REQ_DATA, rand_word());
    offer(REQ_DATA, rand_word());
    for (int i = 0; i < WORDS; i++) offer(REQ_NONCE, '1);
    offer(REQ_DATA, rand_word());
    offer(REQ_DATA, rand_word());
    req_valid <= 1'b0;

    // Most rounds, decryption, all-ones key.
    set_cipher(8'd255, 1'b1, '1);
    for (int i = 0; i < WORDS; i++) offer(REQ_DATA, rand_word());
    req_valid <= 1'b0;

    // Random part. Phases walk through the idling patterns and through
    // round counts, both directions and the key extremes.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       rounds = 8'd4;
        5:       rounds = 8'd255;
        6:       rounds = 8'd1;
        default: rounds = 8'($urandom_range(2, 16));
      endcase
      dec = (p % 3 == 1);
      for (int k = 0; k < KEY_WORDS; k++) begin
        key[k] = (p == 2) ? '0 : (p == 7) ? '1 : rand_word();
      end
      set_cipher(rounds, dec, key);

      case (p % 4)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 80;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 80;
        end
        default: begin
          idle_pct  = 34;
          stall_pct = 34;
        end
      endcase

      // In the first phase the receiver holds off for a long stretch while
      // beats keep coming, so the output buffer, the permutation unit and
      // the gathering stage all fill and the input stalls.
      if (p == 0) hold_asked++;

      // Long blocks at the top round count are kept few.
      quota = (rounds == 8'd255) ? SLOW_ITEMS : PHASE_ITEMS;
      count = 0;
      while (count < quota) send_group(count);
      req_valid <= 1'b0;
    end

    // Let everything drain, then give the verdict.
    settle();
    if (mismatches == 0 && waiting_beats == 0) begin
      $display("wide_block_xorshift_cipher_test passed");
    end else begin
      $display("wide_block_xorshift_cipher_test failed");
    end
    $finish;
  end

endmodule
